/* sv/sfap_pkg.sv */
// ----------------------------------------------------------------------------
// sfap_pkg
// Shared constants and types for the serial frame angle parser.
// ----------------------------------------------------------------------------
package sfap_pkg;

	// frame marker bytes
	localparam logic [7:0] HDR_FIRST  = 8'h55;
	localparam logic [7:0] HDR_SECOND = 8'hAA;
	localparam logic [7:0] TAIL_BYTE  = 8'h0D;

	// number of payload bytes kept for the result
	localparam int unsigned STORE_DEPTH = 8;
	localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

	// parser phases
	typedef enum logic [2:0] {
		PH_HEAD1 = 3'd0,
		PH_HEAD2 = 3'd1,
		PH_CMD   = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4,
		PH_CKSM  = 3'd5,
		PH_TAIL  = 3'd6
	} phase_t;

	// decoded frame handed from the parser to the result register
	typedef struct packed {
		logic        valid;
		logic [31:0] pitch_bits;
		logic [31:0] yaw_bits;
		logic [7:0]  command;
	} frame_t;

endpackage

/* sv/sfap_if.sv */
// ----------------------------------------------------------------------------
// sfap_if
// Valid/ready channels for received bytes and decoded angle frames.
// ----------------------------------------------------------------------------
interface sfap_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfap_angle_if;
	logic        valid;
	logic        ready;
	logic [31:0] pitch_bits;
	logic [31:0] yaw_bits;
	logic [7:0]  command;

	modport source (output valid, output pitch_bits, output yaw_bits, output command,
		input ready);
	modport sink   (input valid, input pitch_bits, input yaw_bits, input command,
		output ready);
endinterface

/* sv/sfap_in_stage.sv */
// ----------------------------------------------------------------------------
// sfap_in_stage
// Input register for received bytes; holds an item while the parser stalls.
// ----------------------------------------------------------------------------
module sfap_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	sfap_rx_if.sink    rx,
	input  logic       adv,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// stage is free when empty or draining this cycle
	assign rx.ready = !valid_s1 || adv;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

/* sv/sfap_fsm.sv */
// ----------------------------------------------------------------------------
// sfap_fsm
// Frame parser: header hunt, command, length, payload store, checksum, tail.
// ----------------------------------------------------------------------------
module sfap_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	output sfap_pkg::frame_t  frame
);

	sfap_pkg::phase_t phase_q, phase_d;
	logic [7:0] command_q, command_d;
	logic [7:0] length_q, length_d;
	logic [7:0] count_q, count_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] store_q [sfap_pkg::STORE_DEPTH];
	logic       store_we;
	logic       frame_valid;
	logic [7:0] count_inc;
	logic [7:0] sum_add;

	assign count_inc = count_q + 8'd1;
	assign sum_add   = sum_q + rx_byte;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= sfap_pkg::PH_HEAD1;
			command_q <= '0;
			length_q  <= '0;
			count_q   <= '0;
			sum_q     <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			command_q <= command_d;
			length_q  <= length_d;
			count_q   <= count_d;
			sum_q     <= sum_d;
		end
	end

	// payload store, first bytes of the payload only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(sfap_pkg::STORE_DEPTH); i++) begin
				store_q[i] <= '0;
			end
		end else if (step && store_we) begin
			store_q[count_q[sfap_pkg::STORE_AW-1:0]] <= rx_byte;
		end
	end

	// next state and result
	always_comb begin
		phase_d     = sfap_pkg::PH_HEAD1;
		command_d   = command_q;
		length_d    = length_q;
		count_d     = count_q;
		sum_d       = sum_q;
		store_we    = 1'b0;
		frame_valid = 1'b0;
		unique case (phase_q)
			sfap_pkg::PH_HEAD2: begin
				phase_d = (rx_byte == sfap_pkg::HDR_SECOND) ? sfap_pkg::PH_CMD
					: sfap_pkg::PH_HEAD1;
			end
			sfap_pkg::PH_CMD: begin
				command_d = rx_byte;
				sum_d     = rx_byte;
				phase_d   = sfap_pkg::PH_LEN;
			end
			sfap_pkg::PH_LEN: begin
				length_d = rx_byte;
				count_d  = '0;
				sum_d    = sum_add;
				phase_d  = (rx_byte != 8'd0) ? sfap_pkg::PH_DATA : sfap_pkg::PH_CKSM;
			end
			sfap_pkg::PH_DATA: begin
				store_we = (count_q < 8'(sfap_pkg::STORE_DEPTH));
				sum_d    = sum_add;
				count_d  = count_inc;
				phase_d  = (count_inc >= length_q) ? sfap_pkg::PH_CKSM : sfap_pkg::PH_DATA;
			end
			sfap_pkg::PH_CKSM: begin
				phase_d = (sum_q == rx_byte) ? sfap_pkg::PH_TAIL : sfap_pkg::PH_HEAD1;
			end
			sfap_pkg::PH_TAIL: begin
				frame_valid = step && (rx_byte == sfap_pkg::TAIL_BYTE);
				phase_d     = sfap_pkg::PH_HEAD1;
			end
			default: begin
				// first header hunt, also unused codes
				phase_d = (rx_byte == sfap_pkg::HDR_FIRST) ? sfap_pkg::PH_HEAD2
					: sfap_pkg::PH_HEAD1;
			end
		endcase
	end

	// little-endian angle words
	assign frame.valid      = frame_valid;
	assign frame.pitch_bits = {store_q[3], store_q[2], store_q[1], store_q[0]};
	assign frame.yaw_bits   = {store_q[7], store_q[6], store_q[5], store_q[4]};
	assign frame.command    = command_q;

endmodule

/* sv/serial_frame_angle_parser.sv */
// ----------------------------------------------------------------------------
// serial_frame_angle_parser
// Parses 0x55 0xAA framed angle commands from a byte stream and returns
// pitch/yaw bit patterns with the command byte on a good frame.
// ----------------------------------------------------------------------------
//  channel | dir | payload                         | handshake
//  rx      | in  | rx_byte[7:0]                    | valid/ready
//  angle   | out | pitch_bits, yaw_bits, command   | valid/ready
//
// one byte accepted per cycle unless the result register stalls
// the input register feeds the parser, whose update and result decode are one
// 8-bit add and compare deep; the result register holds the decoded frame
// arst_n clears the phase, counters, sum, payload store and valid flags
// a stalled result register holds the input register, which then drops rx.ready
module serial_frame_angle_parser (
	input  logic          clk,
	input  logic          arst_n,
	sfap_rx_if.sink       rx,
	sfap_angle_if.source  angle
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             adv;
	sfap_pkg::frame_t frame;
	logic             out_valid_q;

	// parser advances when the result register can take its output
	assign adv = valid_s1 && (!out_valid_q || angle.ready);

	sfap_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	sfap_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (byte_s1),
		.frame   (frame)
	);

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || angle.ready) begin
			out_valid_q <= adv && frame.valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv && frame.valid) begin
			angle.pitch_bits <= frame.pitch_bits;
			angle.yaw_bits   <= frame.yaw_bits;
			angle.command    <= frame.command;
		end
	end

	assign angle.valid = out_valid_q;

	// a new result only follows a byte processed by the parser
	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a parsed byte");

	// a held input byte stays put until the parser takes it
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register lost a stalled byte");

	// the parser never steps while a result waits untaken
	a_no_step_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !angle.ready) |-> !adv)
		else $error("parser stepped while result register was stalled");

endmodule
